FILE: rtl/core/lsom_pkg.sv
`default_nettype none

package lsom_pkg;

  // Field widths.
  localparam int SECTOR_W    = 4;
  localparam int DIST_W      = 8;
  localparam int MS_W        = 8;
  localparam int AGE_W       = 16;
  localparam int MIN_W       = 10;
  localparam int TIMEOUT_W   = 15;
  localparam int THR_W       = 8;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 15;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  localparam int NUM_SECTORS_DEF = 16;

  // Reset and marker values.
  localparam logic [DIST_W-1:0]    RESET_DISTANCE  = 8'd255;
  localparam logic [AGE_W-1:0]     RESET_AGE       = 16'd1000;
  localparam logic [MIN_W-1:0]     NO_FRESH        = 10'd1000;
  localparam logic [TIMEOUT_W-1:0] RESET_TIMEOUT   = 15'd1000;
  localparam logic [THR_W-1:0]     RESET_THRESHOLD = 8'd30;

  // Item kinds carried on in_tuser.
  localparam logic FUNC_STORE = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT   = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD = 1'b1;

  // Arc limits.
  localparam logic [SECTOR_W-1:0] ARC_FWD_LO  = 4'd4;
  localparam logic [SECTOR_W-1:0] ARC_FWD_HI  = 4'd8;
  localparam logic [SECTOR_W-1:0] ARC_BWD_ONE = 4'd0;
  localparam logic [SECTOR_W-1:0] ARC_BWD_LO  = 4'd12;
  localparam logic [SECTOR_W-1:0] ARC_BWD_HI  = 4'd15;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture an accepted item
    logic scan;     // process the sector at the scan index
    logic first;    // first sector of a scan, restart the accumulators
    logic publish;  // move the accumulated result to the output register
  } dp_cmd_t;

  typedef struct packed {
    logic out_free; // output register can take a result this cycle
  } dp_status_t;

  function automatic logic in_arc(input logic [SECTOR_W-1:0] s, input logic backward);
    logic hit;
    if (backward) begin
      hit = (s == ARC_BWD_ONE) || (s inside {[ARC_BWD_LO:ARC_BWD_HI]});
    end else begin
      hit = s inside {[ARC_FWD_LO:ARC_FWD_HI]};
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/lsom_ctrl.sv
`default_nettype none

module lsom_ctrl #(
  parameter int NUM_SECTORS = lsom_pkg::NUM_SECTORS_DEF,
  parameter int IDX_W       = $clog2(NUM_SECTORS)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  lsom_pkg::dp_status_t    status,
  output lsom_pkg::dp_cmd_t       cmd,
  output logic [IDX_W-1:0]        idx
);
  import lsom_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SECTORS - 1);

  logic [1:0]       state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign idx       = cnt_r;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    cmd.load    = 1'b0;
    cmd.scan    = 1'b0;
    cmd.first   = 1'b0;
    cmd.publish = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan  = 1'b1;
        cmd.first = (cnt_r == '0);
        if (cnt_r == LAST_IDX) begin
          state_nxt = ST_FINISH;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_FINISH: begin
        // Hold the result until the output register has room for it.
        if (status.out_free) begin
          cmd.publish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_SCAN) && (cnt_r == '0))
    else $error("accepted item did not start a scan at sector zero");

  a_scan_ends_in_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) && (cnt_r == LAST_IDX) |=> (state_r == ST_FINISH))
    else $error("scan did not end after the last sector");

  a_publish_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |=> in_tready && !$past(in_tready))
    else $error("publish did not return the controller to idle");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/lsom_dp.sv
`default_nettype none

module lsom_dp #(
  parameter int NUM_SECTORS = lsom_pkg::NUM_SECTORS_DEF,
  parameter int IDX_W       = $clog2(NUM_SECTORS)
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  lsom_pkg::dp_cmd_t                        cmd,
  input  wire logic [IDX_W-1:0]                    idx,
  output lsom_pkg::dp_status_t                     status,
  input  wire logic [lsom_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  wire logic                                in_tuser,
  input  wire logic                                cfg_wr_en,
  input  wire logic [lsom_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [lsom_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [lsom_pkg::OUT_TDATA_W-1:0]         out_tdata
);
  import lsom_pkg::*;

  // Per-sector state.
  logic [DIST_W-1:0] dist_r [NUM_SECTORS];
  logic [AGE_W-1:0]  age_r  [NUM_SECTORS];

  logic [TIMEOUT_W-1:0] timeout_r;
  logic [THR_W-1:0]     thr_r;

  // Captured item fields.
  logic            tick_r;
  logic [MS_W-1:0] ms_r;
  logic            dir_r;

  // Scan accumulators.
  logic [MIN_W-1:0] min_r, min_nxt;
  logic             clr_r, clr_nxt;

  logic             out_valid_r;
  logic [MIN_W-1:0] out_min_r;
  logic             out_clr_r;

  // Unpacked input fields.
  logic [SECTOR_W-1:0] in_sector;
  logic [DIST_W-1:0]   in_distance;
  logic [MS_W-1:0]     in_ms;
  logic                in_dir;

  logic [DIST_W-1:0] dist_cur;
  logic [AGE_W-1:0]  age_cur, age_upd, age_new;
  logic [AGE_W:0]    age_sum;
  logic              fresh_old, fresh_new, use_sector;
  logic [MIN_W-1:0]  base_min, dist_ext;
  logic              base_clr;
  logic [IDX_W-1:0]  wr_idx;

  assign in_sector   = in_tdata[3:0];
  assign in_distance = in_tdata[11:4];
  assign in_ms       = in_tdata[19:12];
  assign in_dir      = in_tdata[20];
  assign wr_idx      = in_sector[IDX_W-1:0];

  assign dist_cur  = dist_r[idx];
  assign age_cur   = age_r[idx];
  assign fresh_old = ({1'b0, age_cur} <= {2'b00, timeout_r});
  assign age_sum   = {1'b0, age_cur} + (AGE_W+1)'(ms_r);
  assign age_upd   = age_sum[AGE_W] ? {AGE_W{1'b1}} : age_sum[AGE_W-1:0];
  assign age_new   = (tick_r && fresh_old) ? age_upd : age_cur;
  // Freshness for the query uses the age after this item's tick.
  assign fresh_new  = ({1'b0, age_new} <= {2'b00, timeout_r});
  assign use_sector = fresh_new && in_arc(SECTOR_W'(idx), dir_r);

  assign dist_ext = MIN_W'(dist_cur);
  assign base_min = cmd.first ? NO_FRESH : min_r;
  assign base_clr = cmd.first ? 1'b1 : clr_r;
  assign min_nxt  = (use_sector && (dist_ext < base_min)) ? dist_ext : base_min;
  assign clr_nxt  = base_clr && !(use_sector && (dist_cur < thr_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SECTORS; i++) begin
        dist_r[i] <= RESET_DISTANCE;
        age_r[i]  <= RESET_AGE;
      end
    end else if (cmd.load && (in_tuser == FUNC_STORE)) begin
      dist_r[wr_idx] <= in_distance;
      age_r[wr_idx]  <= '0;
    end else if (cmd.scan) begin
      age_r[idx] <= age_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= RESET_TIMEOUT;
      thr_r     <= RESET_THRESHOLD;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_TIMEOUT:   timeout_r <= cfg_wdata[TIMEOUT_W-1:0];
        REG_THRESHOLD: thr_r     <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tick_r <= (in_tuser == FUNC_TICK);
      ms_r   <= in_ms;
      dir_r  <= in_dir;
    end
    if (cmd.scan) begin
      min_r <= min_nxt;
      clr_r <= clr_nxt;
    end
    if (cmd.publish) begin
      out_min_r <= min_r;
      out_clr_r <= clr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign status.out_free = !out_valid_r || out_tready;
  assign out_tvalid      = out_valid_r;
  assign out_tdata       = {{(OUT_TDATA_W-MIN_W-1){1'b0}}, out_clr_r, out_min_r};

`ifndef NO_ASSERTIONS
  a_publish_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |=> out_valid_r)
    else $error("published result did not appear on the output");

  a_min_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_min_r <= NO_FRESH))
    else $error("minimum distance out of range");

  a_blocked_when_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_min_r < MIN_W'(thr_r)) |-> !out_clr_r)
    else $error("path reported clear with a fresh sector below threshold");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/lidar_sector_obstacle_monitor_unit.sv
`default_nettype none

// Channel  Dir  Payload
// in_      in   tuser: func; tdata: sector[3:0] distance[11:4] elapsed_ms[19:12]
//                direction[20], zero fill to 24 bits
// out_     out  tdata: min_distance[9:0] path_clear[10], zero fill to 16 bits
// cfg_     in   wr_en, addr (0 stale_timeout_ms, 1 obstacle_threshold), wdata
//
// Each item is accepted in the idle state, then the sector tables are scanned one sector
// at a time from sector zero up, then the result is handed to the output register.
// The next item is accepted while the previous result waits on out_tready.
// A stalled output holds the scan at its last step until the register frees.
// Reset (rst_n low, synchronous) restores tables, config, control and out_tvalid at once.
module lidar_sector_obstacle_monitor_unit #(
  parameter int NUM_SECTORS = lsom_pkg::NUM_SECTORS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // tdata: sector, distance, elapsed_ms, direction (lowest bit first)
  input  wire logic [lsom_pkg::IN_TDATA_W-1:0] in_tdata,
  // tuser: func
  input  wire logic                            in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // tdata: min_distance, path_clear (lowest bit first)
  output logic [lsom_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  wire logic                            cfg_wr_en,
  input  wire logic [lsom_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [lsom_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import lsom_pkg::*;

  localparam int IDX_W = $clog2(NUM_SECTORS);

  dp_cmd_t          cmd;
  dp_status_t       status;
  logic [IDX_W-1:0] idx;

  lsom_ctrl #(
    .NUM_SECTORS (NUM_SECTORS),
    .IDX_W       (IDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd),
    .idx       (idx)
  );

  lsom_dp #(
    .NUM_SECTORS (NUM_SECTORS),
    .IDX_W       (IDX_W)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .idx        (idx),
    .status     (status),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

FILE: bench/tb_lidar_sector_obstacle_monitor_unit.sv
`timescale 1ns / 100ps

module tb_lidar_sector_obstacle_monitor_unit;
  import lsom_pkg::*;

  localparam logic DIR_FORWARD  = 1'b0;
  localparam logic DIR_BACKWARD = 1'b1;

  typedef struct packed {
    logic [MIN_W-1:0] min_distance;
    logic             path_clear;
  } arc_report_t;

  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e                kind;
    logic                     func;
    logic [SECTOR_W-1:0]      sector;
    logic [DIST_W-1:0]        distance;
    logic [MS_W-1:0]          ms;
    logic                     dir;
    logic                     typed;
    arc_report_t              want;
    logic [CFG_ADDR_W-1:0]    reg_addr;
    logic [CFG_DATA_W-1:0]    reg_value;
  } directed_row_t;

  localparam int NUM_ROWS = 27;

  // Rows with typed = 1 carry a hand-worked report; the rest use the predictor.
  directed_row_t directed_rows [0:NUM_ROWS-1] = '{
    '{ROW_ITEM, FUNC_TICK,  4'd0,  8'd0,   8'd0,   DIR_FORWARD,  1'b1, '{10'd255,  1'b1},
      REG_TIMEOUT, 15'd0},
    '{ROW_ITEM, FUNC_TICK,  4'd15, 8'd255, 8'd0,   DIR_BACKWARD, 1'b1, '{10'd255,  1'b1},
      REG_TIMEOUT, 15'd0},
    '{ROW_ITEM, FUNC_TICK,  4'd0,  8'd0,   8'd1,   DIR_FORWARD,  1'b1, '{10'd1000, 1'b1},
      REG_TIMEOUT, 15'd0},
    '{ROW_ITEM, FUNC_TICK,  4'd0,  8'd0,   8'd255, DIR_BACKWARD, 1'b1, '{10'd1000, 1'b1},
      REG_TIMEOUT, 15'd0},
    '{ROW_ITEM, FUNC_STORE, 4'd4,  8'd0,   8'd255, DIR_FORWARD,  1'b1, '{10'd0,    1'b0},
      REG_TIMEOUT, 15'd0},
    '{ROW_ITEM, FUNC_STORE, 4'd8,  8'd29,  8'd0,   DIR_FORWARD,  1'b1, '{10'd0,    1'b0},
      REG_TIMEOUT, 15'd0},
    '{ROW_ITEM, FUNC_STORE, 4'd0,  8'd30,  8'd0,   DIR_BACKWARD, 1'b1, '{10'd30,   1'b1},
      REG_TIMEOUT, 15'd0},
    '{ROW_ITEM, FUNC_STORE, 4'd15, 8'd29,  8'd0,   DIR_BACKWARD, 1'b1, '{10'd29,   1'b0},
      REG_TIMEOUT, 15'd0},
    '{ROW_ITEM, FUNC_STORE, 4'd12, 8'd255, 8'd170, DIR_BACKWARD, 1'b1, '{10'd29,   1'b0},
      REG_TIMEOUT, 15'd0},
    '{ROW_ITEM, FUNC_STORE, 4'd3,  8'd5,   8'd0,   DIR_FORWARD,  1'b1, '{10'd0,    1'b0},
      REG_TIMEOUT, 15'd0},
    '{ROW_ITEM, FUNC_STORE, 4'd9,  8'd1,   8'd0,   DIR_BACKWARD, 1'b1, '{10'd29,   1'b0},
      REG_TIMEOUT, 15'd0},
    '{ROW_ITEM, FUNC_STORE, 4'd13, 8'd200, 8'd0,   DIR_FORWARD,  1'b0, '{10'd0,    1'b0},
      REG_TIMEOUT, 15'd0},
    '{ROW_ITEM, FUNC_STORE, 4'd4,  8'd255, 8'd0,   DIR_FORWARD,  1'b0, '{10'd0,    1'b0},
      REG_TIMEOUT, 15'd0},
    '{ROW_ITEM, FUNC_TICK,  4'd0,  8'd0,   8'd255, DIR_FORWARD,  1'b0, '{10'd0,    1'b0},
      REG_TIMEOUT, 15'd0},
    '{ROW_ITEM, FUNC_TICK,  4'd0,  8'd0,   8'd255, DIR_BACKWARD, 1'b0, '{10'd0,    1'b0},
      REG_TIMEOUT, 15'd0},
    '{ROW_REG,  FUNC_STORE, 4'd0,  8'd0,   8'd0,   DIR_FORWARD,  1'b0, '{10'd0,    1'b0},
      REG_THRESHOLD, 15'd0},
    '{ROW_ITEM, FUNC_STORE, 4'd5,  8'd0,   8'd0,   DIR_FORWARD,  1'b1, '{10'd0,    1'b1},
      REG_TIMEOUT, 15'd0},
    '{ROW_REG,  FUNC_STORE, 4'd0,  8'd0,   8'd0,   DIR_FORWARD,  1'b0, '{10'd0,    1'b0},
      REG_TIMEOUT, 15'd0},
    '{ROW_ITEM, FUNC_TICK,  4'd0,  8'd0,   8'd0,   DIR_FORWARD,  1'b1, '{10'd0,    1'b1},
      REG_TIMEOUT, 15'd0},
    '{ROW_ITEM, FUNC_TICK,  4'd0,  8'd0,   8'd1,   DIR_FORWARD,  1'b1, '{10'd1000, 1'b1},
      REG_TIMEOUT, 15'd0},
    '{ROW_ITEM, FUNC_STORE, 4'd14, 8'd255, 8'd0,   DIR_BACKWARD, 1'b1, '{10'd255,  1'b1},
      REG_TIMEOUT, 15'd0},
    // Raising the timeout brings the long-stale sectors back into play.
    '{ROW_REG,  FUNC_STORE, 4'd0,  8'd0,   8'd0,   DIR_FORWARD,  1'b0, '{10'd0,    1'b0},
      REG_TIMEOUT, 15'd30000},
    '{ROW_REG,  FUNC_STORE, 4'd0,  8'd0,   8'd0,   DIR_FORWARD,  1'b0, '{10'd0,    1'b0},
      REG_THRESHOLD, 15'd255},
    '{ROW_ITEM, FUNC_TICK,  4'd0,  8'd0,   8'd255, DIR_FORWARD,  1'b0, '{10'd0,    1'b0},
      REG_TIMEOUT, 15'd0},
    '{ROW_ITEM, FUNC_TICK,  4'd0,  8'd0,   8'd0,   DIR_BACKWARD, 1'b0, '{10'd0,    1'b0},
      REG_TIMEOUT, 15'd0},
    '{ROW_ITEM, FUNC_STORE, 4'd7,  8'd254, 8'd0,   DIR_FORWARD,  1'b0, '{10'd0,    1'b0},
      REG_TIMEOUT, 15'd0},
    '{ROW_ITEM, FUNC_STORE, 4'd2,  8'd128, 8'd0,   DIR_BACKWARD, 1'b0, '{10'd0,    1'b0},
      REG_TIMEOUT, 15'd0}
  };

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [IN_TDATA_W-1:0]    in_tdata;
  logic                     in_tuser;
  logic                     out_tvalid;
  logic                     out_tready;
  logic [OUT_TDATA_W-1:0]   out_tdata;
  logic                     cfg_wr_en;
  logic [CFG_ADDR_W-1:0]    cfg_addr;
  logic [CFG_DATA_W-1:0]    cfg_wdata;

  // Shadow of the block's sector tables and registers.
  logic [DIST_W-1:0]        dist_table [NUM_SECTORS_DEF];
  logic [AGE_W-1:0]         age_table [NUM_SECTORS_DEF];
  logic [TIMEOUT_W-1:0]     timeout_reg;
  logic [THR_W-1:0]         threshold_reg;

  arc_report_t              pending_reports [$];
  int                       tx_idle_pct = 0;
  int                       rx_idle_pct = 0;
  int                       items_sent = 0;
  int                       directed_items = 0;
  int                       reg_writes = 0;
  int                       reports_checked = 0;
  int                       error_count = 0;

  lidar_sector_obstacle_monitor_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic logic sector_in_arc(input int s, input logic dir);
    if (dir == DIR_BACKWARD) begin
      return (s == ARC_BWD_ONE) || (s >= ARC_BWD_LO && s <= ARC_BWD_HI);
    end
    return s >= ARC_FWD_LO && s <= ARC_FWD_HI;
  endfunction

  // Applies one item to the shadow tables and returns the report it causes.
  function automatic arc_report_t predict_arc_report(
    input logic func, input logic [SECTOR_W-1:0] sector, input logic [DIST_W-1:0] distance,
    input logic [MS_W-1:0] ms, input logic dir
  );
    arc_report_t     rep;
    logic [AGE_W:0]  grown;
    rep.min_distance = NO_FRESH;
    rep.path_clear   = 1'b1;
    if (func == FUNC_STORE) begin
      dist_table[sector] = distance;
      age_table[sector]  = '0;
    end else begin
      for (int s = 0; s < NUM_SECTORS_DEF; s++) begin
        if (age_table[s] <= timeout_reg) begin
          grown        = {1'b0, age_table[s]} + (AGE_W+1)'(ms);
          age_table[s] = grown[AGE_W] ? '1 : grown[AGE_W-1:0];
        end
      end
    end
    for (int s = 0; s < NUM_SECTORS_DEF; s++) begin
      if (sector_in_arc(s, dir) && age_table[s] <= timeout_reg) begin
        if (dist_table[s] < rep.min_distance) rep.min_distance = MIN_W'(dist_table[s]);
        if (dist_table[s] < threshold_reg) rep.path_clear = 1'b0;
      end
    end
    return rep;
  endfunction

  // Holds the sender back until every outstanding report has come out.
  task automatic drain_reports();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] value);
    drain_reports();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    if (addr == REG_TIMEOUT) begin
      timeout_reg = value[TIMEOUT_W-1:0];
    end else if (addr == REG_THRESHOLD) begin
      threshold_reg = value[THR_W-1:0];
    end
    reg_writes++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_item(input logic func, input logic [SECTOR_W-1:0] sector,
                           input logic [DIST_W-1:0] distance, input logic [MS_W-1:0] ms,
                           input logic dir, input logic typed, input arc_report_t typed_rep);
    arc_report_t rep;
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {3'b000, dir, ms, distance, sector};
    do @(posedge clk); while (!in_tready);
    rep = predict_arc_report(func, sector, distance, ms, dir);
    pending_reports.push_back(typed ? typed_rep : rep);
    items_sent++;
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    arc_report_t got;
    arc_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.min_distance = out_tdata[MIN_W-1:0];
      got.path_clear   = out_tdata[MIN_W];
      if (pending_reports.size() == 0) begin
        $error("unexpected item on out: min_distance %0d path_clear %0d",
               got.min_distance, got.path_clear);
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        if (got.min_distance !== want.min_distance) begin
          $error("min_distance: expected %0d, actual %0d", want.min_distance,
                 got.min_distance);
          error_count++;
        end
        if (got.path_clear !== want.path_clear) begin
          $error("path_clear: expected %0d, actual %0d", want.path_clear, got.path_clear);
          error_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    directed_row_t            row;
    logic                     func;
    logic [SECTOR_W-1:0]      sector;
    logic [DIST_W-1:0]        distance;
    logic [MS_W-1:0]          ms;
    logic                     dir;
    logic [TIMEOUT_W-1:0]     new_timeout;
    logic [THR_W-1:0]         new_threshold;
    int                       near;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = FUNC_STORE;
    out_tready = 1'b0;
    cfg_wr_en  = 1'b0;
    cfg_addr   = REG_TIMEOUT;
    cfg_wdata  = '0;
    timeout_reg   = RESET_TIMEOUT;
    threshold_reg = RESET_THRESHOLD;
    for (int s = 0; s < NUM_SECTORS_DEF; s++) begin
      dist_table[s] = RESET_DISTANCE;
      age_table[s]  = RESET_AGE;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 16;
    rx_idle_pct = 53;
    for (int i = 0; i < NUM_ROWS; i++) begin
      row = directed_rows[i];
      if (row.kind == ROW_REG) begin
        write_reg(row.reg_addr, row.reg_value);
      end else begin
        send_item(row.func, row.sector, row.distance, row.ms, row.dir, row.typed, row.want);
        directed_items++;
      end
    end

    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 2) begin
        tx_idle_pct = 53;
        rx_idle_pct = 16;
      end else if (phase == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (phase)
        0: begin new_timeout = 15'd0;     new_threshold = 8'd255; end
        1: begin new_timeout = 15'd30000; new_threshold = 8'd0;   end
        2: begin
          new_timeout   = TIMEOUT_W'($urandom_range(1500));
          new_threshold = THR_W'($urandom_range(255));
        end
        3: begin new_timeout = 15'd30000; new_threshold = 8'd255; end
        4: begin new_timeout = 15'd0;     new_threshold = 8'd0;   end
        default: begin
          new_timeout   = TIMEOUT_W'($urandom_range(2000, 200));
          new_threshold = THR_W'($urandom_range(255));
        end
      endcase
      write_reg(REG_TIMEOUT, CFG_DATA_W'(new_timeout));
      write_reg(REG_THRESHOLD, CFG_DATA_W'(new_threshold));
      for (int n = 0; n < 84; n++) begin
        func   = ($urandom_range(99) < 60) ? FUNC_STORE : FUNC_TICK;
        sector = SECTOR_W'($urandom_range(15));
        dir    = 1'($urandom_range(1));
        // A quarter of the distances land right around the threshold.
        if ($urandom_range(3) == 0) begin
          near = int'(threshold_reg) + int'($urandom_range(2)) - 1;
          distance = (near < 0) ? 8'd0 : (near > 255) ? 8'd255 : near[7:0];
        end else begin
          distance = DIST_W'($urandom_range(255));
        end
        ms = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255));
        send_item(func, sector, distance, ms, dir, 1'b0, '0);
        if ($urandom_range(63) == 0) drain_reports();
      end
    end

    drain_reports();
    repeat (40) @(posedge clk);

    $display("Ran %0d items (%0d from the directed table) with %0d register writes;",
             items_sent, directed_items, reg_writes);
    $display("%0d arc reports compared across three handshake stall patterns.",
             reports_checked);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: lidar_sector_obstacle_monitor_unit.f
rtl/core/lsom_pkg.sv
rtl/core/lsom_ctrl.sv
rtl/core/lsom_dp.sv
rtl/core/lidar_sector_obstacle_monitor_unit.sv
bench/tb_lidar_sector_obstacle_monitor_unit.sv
